[rtl/lidar_frame_parser_core_assert.svh]
// assertion macros for the lidar frame parser
`ifndef LIDAR_FRAME_PARSER_CORE_ASSERT_SVH
`define LIDAR_FRAME_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfp assertion failed");
`define LFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfp assertion failed");
`else
`define LFP_ASSERT_NOW(lbl, ante, cons)
`define LFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/lfp_pkg.sv]
package lfp_pkg;

  localparam logic [7:0]  HDR_FIRST        = 8'hA5;
  localparam logic [7:0]  HDR_SECOND       = 8'h5A;
  localparam logic [19:0] FULL_TURN        = 20'd576000;
  localparam logic [19:0] MIRROR_ANGLE     = 20'd712000;
  localparam logic [16:0] TURN_HUNDREDTHS  = 17'd36000;
  localparam int          POINTS_PER_FRAME = 16;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_burst;
  } in_item_t;

  typedef struct packed {
    logic [15:0] point_distance;
    logic [19:0] point_angle;
    logic [9:0]  point_index;
    logic        last_of_run;
  } out_item_t;

endpackage

[rtl/lfp_ram.sv]
module lfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/lidar_frame_parser_core.sv]
// lidar scan frame parser
// input channel: one received uart word per transfer (byte plus end-of-burst flag),
//   taken when in_valid_i is high and in_stall_o is low
// output channel: one point per transfer (distance, angle in 1/1600 degree, slot index,
//   last flag), taken when out_valid_o is high and out_stall_i is low
// every word is written to a circular byte history in a one-port-write, one-port-read ram;
// all frame fields are fetched back from that ram one byte at a time
// a word that starts nothing is only stored; a header candidate while hunting adds header
// reads; a decoded frame costs angle reads plus distance reads for each point, and lock
// releases two frames in a row; the fetch waits while the receiver stalls
// in_stall_o stays high while hunting or while a frame is being fetched; a point waits
// in the output register while out_stall_i is high, and the fetch engine waits behind it
// reset clears lock, frame position, slot and fill count; the history is not cleared and
// hunting waits until 2*FRAME_BYTES+2 bytes of the burst have been seen
module lidar_frame_parser_core
  import lfp_pkg::*;
#(
  parameter int FRAME_BYTES   = 58,
  parameter int MAX_POINTS    = 1024,
  parameter int HISTORY_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

`include "lidar_frame_parser_core_assert.svh"

  localparam int SCAN_SPAN = 2 * FRAME_BYTES + 2;
  localparam int IW        = $clog2(SCAN_SPAN + 1);
  localparam int AW        = $clog2(HISTORY_DEPTH);
  localparam int CW        = ((AW > IW) ? AW : IW) + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_HUNT, ST_HDR, ST_PT} state_e;

  state_e          state_q;
  logic [2:0]      step_q;
  logic            hunt_ok_q;
  logic [IW-1:0]   base_q;
  logic            second_q;
  logic            eob_q;
  logic            locked_q;
  logic [5:0]      pos_q;
  logic            hg_q;
  logic [5:0]      slot_q;
  logic [5:0]      cur_slot_q;
  logic [IW-1:0]   fill_q;
  logic [AW-1:0]   wp_q;
  logic [7:0]      prev_q;
  logic [15:0]     s_q;
  logic [7:0]      shi_q, ehi_q, dhi_q, dlo_q;
  logic [17:0]     span_q;
  logic [19:0]     a_q;
  logic [3:0]      k_q;
  logic [IW-1:0]   didx_q;
  logic            oob_q;
  logic            out_valid_q;
  out_item_t       out_q;

  // ram access
  logic [IW-1:0]   rd_idx;
  logic            re;
  logic [AW-1:0]   raddr, wp_d;
  logic [CW-1:0]   wp_ext, idx_ext, addr_ext;
  logic [7:0]      ram_rdata, rdat;
  logic            accept;

  // arithmetic
  logic [15:0]     e_val;
  logic [16:0]     e_adj;
  logic [17:0]     span_full;
  logic [19:0]     a_init_raw, a_init;
  logic [21:0]     a_sum;
  logic [19:0]     a_next, m_raw, m_val;
  logic            emit, last_pt, out_take;

  // byte handling
  logic [IW-1:0]   fill_d;
  logic            hdr_now, hg_d;

  function automatic logic slot_open(input logic [5:0] s);
    return 11'({s, 4'b0000}) < 11'(MAX_POINTS - POINTS_PER_FRAME);
  endfunction

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign wp_d     = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);

  always_comb begin
    rd_idx = '0;
    re     = 1'b0;
    case (state_q)
      ST_HUNT: begin
        re = (step_q < 3'd4);
        case (step_q)
          3'd0:    rd_idx = IW'(2 * FRAME_BYTES + 1);
          3'd1:    rd_idx = IW'(2 * FRAME_BYTES);
          3'd2:    rd_idx = IW'(FRAME_BYTES + 1);
          default: rd_idx = IW'(FRAME_BYTES);
        endcase
      end
      ST_HDR: begin
        re = (step_q < 3'd4);
        case (step_q)
          3'd0:    rd_idx = base_q - IW'(5);
          3'd1:    rd_idx = base_q - IW'(6);
          3'd2:    rd_idx = base_q - IW'(55);
          default: rd_idx = base_q - IW'(56);
        endcase
      end
      ST_PT: begin
        re     = (step_q < 3'd2);
        rd_idx = (step_q == 3'd0) ? didx_q : didx_q - IW'(1);
      end
      default: ;
    endcase
  end

  // newest byte sits at wp_q; history index i lives at wp_q - i, wrapped
  assign wp_ext   = CW'(wp_q);
  assign idx_ext  = CW'(rd_idx);
  assign addr_ext = (wp_ext >= idx_ext) ? wp_ext - idx_ext
                                        : wp_ext + CW'(HISTORY_DEPTH) - idx_ext;
  assign raddr    = addr_ext[AW-1:0];

  lfp_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_d),
    .wdata_i (in_data_i.byte_value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // indices past the history read as zero
  assign rdat = oob_q ? 8'h00 : ram_rdata;

  // start/end angle and first point
  assign e_val      = {ehi_q, rdat};
  assign e_adj      = {1'b0, e_val} + ((s_q > e_val) ? TURN_HUNDREDTHS : 17'd0);
  // two's complement, negative when a start above 360 degrees wraps past the end
  assign span_full  = {1'b0, e_adj} - {2'b00, s_q};
  assign a_init_raw = {s_q, 4'b0000};
  assign a_init     = (a_init_raw > FULL_TURN) ? a_init_raw - FULL_TURN : a_init_raw;

  // step to the next point; a positive span folds down once, a negative one folds up once
  assign a_sum  = {2'b00, a_q} + {{4{span_q[17]}}, span_q};
  assign a_next = (span_q[17] && (a_sum[21] || (a_sum == '0))) ? 20'(a_sum + 22'(FULL_TURN))
                : (a_sum > 22'(FULL_TURN)) ? 20'(a_sum - 22'(FULL_TURN)) : a_sum[19:0];
  assign m_raw  = MIRROR_ANGLE - a_q;
  assign m_val  = (m_raw > FULL_TURN) ? m_raw - FULL_TURN : m_raw;

  assign out_take = out_valid_q && !out_stall_i;
  assign emit     = (state_q == ST_PT) && (step_q == 3'd3) && (!out_valid_q || !out_stall_i);
  assign last_pt  = (k_q == 4'd15) && !second_q;

  assign fill_d  = (fill_q < IW'(SCAN_SPAN)) ? fill_q + IW'(1) : fill_q;
  assign hdr_now = (prev_q == HDR_FIRST) && (in_data_i.byte_value == HDR_SECOND);
  assign hg_d    = (pos_q == 6'd1) ? hdr_now : hg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      locked_q    <= 1'b0;
      pos_q       <= '0;
      hg_q        <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      wp_q        <= '0;
      second_q    <= 1'b0;
      eob_q       <= 1'b0;
      hunt_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (re) begin
        oob_q <= (idx_ext >= CW'(HISTORY_DEPTH));
      end
      if (out_take) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            wp_q   <= wp_d;
            prev_q <= in_data_i.byte_value;
            fill_q <= fill_d;
            eob_q  <= in_data_i.end_of_burst;
            step_q <= '0;
            if (locked_q) begin
              hg_q <= hg_d;
              if (pos_q >= 6'(FRAME_BYTES - 1)) begin
                pos_q <= '0;
                if (slot_open(slot_q)) begin
                  slot_q <= slot_q + 6'd1;
                  if (hg_d) begin
                    state_q    <= ST_HDR;
                    base_q     <= IW'(FRAME_BYTES - 1);
                    cur_slot_q <= slot_q;
                    second_q   <= 1'b0;
                  end
                end
              end else begin
                pos_q <= pos_q + 6'd1;
              end
            end else if ((fill_d == IW'(SCAN_SPAN)) && hdr_now) begin
              state_q   <= ST_HUNT;
              hunt_ok_q <= 1'b1;
            end
            // nothing started: drop the lock right away on burst end
            if (in_data_i.end_of_burst && !(locked_q && (pos_q >= 6'(FRAME_BYTES - 1))
                && slot_open(slot_q) && hg_d)
                && !(!locked_q && (fill_d == IW'(SCAN_SPAN)) && hdr_now)) begin
              locked_q <= 1'b0;
              fill_q   <= '0;
              pos_q    <= '0;
              hg_q     <= 1'b0;
              slot_q   <= '0;
            end
          end
        end

        ST_HUNT: begin
          step_q <= step_q + 3'd1;
          if (step_q != 3'd0) begin
            if (rdat != (step_q[0] ? HDR_FIRST : HDR_SECOND)) begin
              hunt_ok_q <= 1'b0;
            end
          end
          if (step_q == 3'd4) begin
            step_q <= '0;
            if (hunt_ok_q && (rdat == HDR_SECOND)) begin
              locked_q   <= 1'b1;
              slot_q     <= 6'd2;
              pos_q      <= 6'd2;
              hg_q       <= 1'b1;
              state_q    <= ST_HDR;
              base_q     <= IW'(2 * FRAME_BYTES + 1);
              cur_slot_q <= 6'd0;
              second_q   <= 1'b1;
            end else begin
              state_q <= ST_IDLE;
              if (eob_q) begin
                fill_q <= '0;
              end
            end
          end
        end

        ST_HDR: begin
          step_q <= step_q + 3'd1;
          case (step_q)
            3'd1: shi_q <= rdat;
            3'd2: s_q   <= {shi_q, rdat};
            3'd3: ehi_q <= rdat;
            3'd4: begin
              span_q  <= span_full;
              a_q     <= a_init;
              k_q     <= '0;
              didx_q  <= base_q - IW'(7);
              step_q  <= '0;
              state_q <= ST_PT;
            end
            default: ;
          endcase
        end

        ST_PT: begin
          if (step_q == 3'd1) begin
            dhi_q <= rdat;
          end
          if (step_q == 3'd2) begin
            dlo_q <= rdat;
          end
          if (step_q != 3'd3) begin
            step_q <= step_q + 3'd1;
          end
          if (emit) begin
            out_valid_q          <= 1'b1;
            out_q.point_distance <= {dhi_q, dlo_q};
            out_q.point_angle    <= m_val;
            out_q.point_index    <= {cur_slot_q, k_q};
            out_q.last_of_run    <= last_pt;
            a_q                  <= a_next;
            k_q                  <= k_q + 4'd1;
            didx_q               <= didx_q - IW'(3);
            step_q               <= '0;
            if (k_q == 4'd15) begin
              if (second_q) begin
                state_q    <= ST_HDR;
                base_q     <= IW'(FRAME_BYTES + 1);
                cur_slot_q <= 6'd1;
                second_q   <= 1'b0;
              end else begin
                state_q <= ST_IDLE;
                if (eob_q) begin
                  locked_q <= 1'b0;
                  fill_q   <= '0;
                  pos_q    <= '0;
                  hg_q     <= 1'b0;
                  slot_q   <= '0;
                end
              end
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LFP_ASSERT_NOW(a_lock_full, locked_q, fill_q == IW'(SCAN_SPAN))
  `LFP_ASSERT_NOW(a_pos_range, locked_q, {1'b0, pos_q} < 7'(FRAME_BYTES))
  `LFP_ASSERT_NOW(a_angle_range, out_valid_q, out_q.point_angle <= FULL_TURN)
  `LFP_ASSERT_NEXT(a_last_idle, emit && last_pt, state_q == ST_IDLE)

endmodule
